/* hdl/nfba_pkg.sv */
// ----------------------------------------------------------------------------
// nfba_pkg
// Types, codes and widths shared by the next-fit block allocator modules.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int NUM_BLOCKS = 1024;

  localparam int REQ_W   = 24;  // request size in bytes
  localparam int UNIT_W  = 16;  // bytes per block
  localparam int CNT_W   = 11;  // pool size, rover, in-use count
  localparam int LEN_W   = 11;  // stored run length
  localparam int POS_W   = 12;  // search position, may pass the pool end
  localparam int IDX_W   = 10;  // block index on the ports
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [UNIT_W-1:0] UNIT_RESET  = 16'd64;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 11'd2047;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_SIZE = 2'd2,
    STAT_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic {
    REG_UNIT_BYTES  = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_START,
    S_ITER,
    S_CHK,
    S_FREE
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [IDX_W-1:0]  free_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  block_index;
    logic [CNT_W-1:0]  blocks_in_use;
  } rsp_t;

  typedef struct packed {
    logic              done;
    logic [REQ_W-1:0]  quotient;
    logic              rem_nz;
  } div_res_t;

endpackage

/* hdl/nfba_ram.sv */
// ----------------------------------------------------------------------------
// nfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfba_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/nfba_div.sv */
// ----------------------------------------------------------------------------
// nfba_div
// Restoring divider, one quotient bit per cycle; reports quotient and
// whether a remainder is left.
// ----------------------------------------------------------------------------
module nfba_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nfba_pkg::REQ_W-1:0]   dividend_i,
  input  logic [nfba_pkg::UNIT_W-1:0]  divisor_i,
  output nfba_pkg::div_res_t           res_o
);
  import nfba_pkg::*;

  localparam int StepW = $clog2(REQ_W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [REQ_W-1:0] quo_q, quo_d;
  logic [UNIT_W-1:0] rem_q, rem_d;
  logic [UNIT_W-1:0] dsr_q, dsr_d;

  logic [UNIT_W:0]   trial;
  logic [UNIT_W+1:0] diff;
  logic              borrow;

  assign trial  = {rem_q, quo_q[REQ_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, dsr_q};
  assign borrow = diff[UNIT_W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (run_q) begin
      quo_d  = {quo_q[REQ_W-2:0], ~borrow};
      rem_d  = borrow ? trial[UNIT_W-1:0] : diff[UNIT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(REQ_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.rem_nz   = |rem_q;

endmodule

/* hdl/next_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over a pool of fixed-size blocks: allocate and free
// requests, block map and run lengths held in RAM, searched one block a cycle.
//
//   port group          direction  handshake
//   start/req_i/busy    in         taken when start && !busy
//   done_o/rsp_o        out        one-cycle strobe, always taken
//   psel..pready        cfg        APB write/read, pready tied high
//
// Allocate: division, S_START setup, then per search step an S_ITER state
//   plus an S_CHK state per block probed (one RAM read port sets the pace).
// Free: S_FREE alone. The result strobe follows the last busy cycle of either.
// After reset a pass clears all NumBlocks head marks before busy drops.
// Results cannot be stalled; the next request may be taken during done_o.
// ----------------------------------------------------------------------------
module next_fit_block_allocator #(
  parameter int NumBlocks = nfba_pkg::NUM_BLOCKS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  nfba_pkg::req_t               req_i,
  output logic                         done_o,
  output nfba_pkg::rsp_t               rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nfba_pkg::APB_AW-1:0]  paddr,
  input  logic [nfba_pkg::APB_DW-1:0]  pwdata,
  output logic [nfba_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import nfba_pkg::*;

  localparam int AddrW = $clog2(NumBlocks);

  state_e            state_q, state_d;
  logic [UNIT_W-1:0] unit_q;
  logic [CNT_W-1:0]  bcnt_q;
  logic [CNT_W-1:0]  rover_q, rover_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              wrapped_q, wrapped_d;
  logic              done_q, done_d;

  logic [LEN_W-1:0]  s_q, s_d;
  logic [CNT_W-1:0]  last_q, last_d;
  logic [POS_W-1:0]  i_q, i_d;
  logic [POS_W-1:0]  j_q, j_d;
  logic [POS_W-1:0]  end_q, end_d;
  logic              range_bad_q, range_bad_d;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic              div_start;
  logic [UNIT_W-1:0] divisor;
  div_res_t          div_res;

  logic [CNT_W-1:0]  pool_n;
  logic [REQ_W:0]    s_full;
  logic              size_bad;

  logic              head_we;
  logic [AddrW-1:0]  head_waddr;
  logic              head_wdata;
  logic              head_rd;
  logic              len_we;
  logic [LEN_W-1:0]  len_rd;
  logic [AddrW-1:0]  raddr;

  logic [LEN_W-1:0]  hop;
  logic [POS_W-1:0]  i_new;
  logic [POS_W-1:0]  j_inc;
  logic              fail;
  logic              past_last;
  logic [CNT_W:0]    sum;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_RESET;
      bcnt_q <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_e'(paddr[2]))
        REG_UNIT_BYTES:  unit_q <= pwdata[UNIT_W-1:0];
        REG_BLOCK_COUNT: bcnt_q <= pwdata[CNT_W-1:0];
        default:         unit_q <= unit_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_UNIT_BYTES:  prdata = APB_DW'(unit_q);
      REG_BLOCK_COUNT: prdata = APB_DW'(bcnt_q);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pool size and request size
  assign pool_n = (bcnt_q == '0) ? CNT_W'(1) :
                  (32'(bcnt_q) > NumBlocks) ? CNT_W'(NumBlocks) : bcnt_q;
  assign divisor  = (unit_q == '0) ? UNIT_W'(1) : unit_q;
  assign s_full   = {1'b0, div_res.quotient} + (REQ_W+1)'(div_res.rem_nz);
  assign size_bad = (s_full == '0) || (s_full > (REQ_W+1)'(pool_n));

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign div_start = accept && (req_i.kind == KIND_ALLOC);

  nfba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.request_bytes),
    .divisor_i  (divisor),
    .res_o      (div_res)
  );

  nfba_ram #(
    .Width (1),
    .Depth (NumBlocks)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (raddr),
    .rdata_o (head_rd)
  );

  nfba_ram #(
    .Width (LEN_W),
    .Depth (NumBlocks)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (AddrW'(i_q)),
    .wdata_i (s_q),
    .raddr_i (raddr),
    .rdata_o (len_rd)
  );

  // search arithmetic
  assign hop       = (len_rd == '0) ? LEN_W'(1) : len_rd;
  assign i_new     = j_q + POS_W'(hop);
  assign j_inc     = j_q + POS_W'(1);
  assign past_last = i_new > POS_W'(last_q);
  assign fail      = wrapped_q && ((i_new >= POS_W'(rover_q)) || past_last);
  assign sum       = {1'b0, count_q} + (CNT_W+1)'(s_q);
  assign raddr     = AddrW'(j_d);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AddrW'(NumBlocks - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (req_i.kind == KIND_FREE) ? S_FREE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_d = size_bad ? S_IDLE : S_START;
        end
      end
      S_START: state_d = S_ITER;
      S_ITER:  state_d = S_CHK;
      S_CHK: begin
        if (head_rd) begin
          state_d = fail ? S_IDLE : S_ITER;
        end else if (j_inc == end_q) begin
          state_d = S_IDLE;
        end
      end
      S_FREE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rover_d     = rover_q;
    count_d     = count_q;
    clr_d       = clr_q;
    wrapped_d   = wrapped_q;
    done_d      = 1'b0;
    s_d         = s_q;
    last_d      = last_q;
    i_d         = i_q;
    j_d         = j_q;
    end_d       = end_q;
    range_bad_d = range_bad_q;
    rsp_d       = rsp_q;
    head_we     = 1'b0;
    head_waddr  = AddrW'(i_q);
    head_wdata  = 1'b0;
    len_we      = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        clr_d      = clr_q + AddrW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          j_d         = POS_W'(req_i.free_index);
          range_bad_d = 32'(req_i.free_index) >= NumBlocks;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          s_d    = LEN_W'(s_full);
          last_d = pool_n - CNT_W'(s_full);
          if (size_bad) begin
            done_d              = 1'b1;
            rsp_d.status        = STAT_BAD_SIZE;
            rsp_d.block_index   = '0;
            rsp_d.blocks_in_use = count_q;
          end
        end
      end
      S_START: begin
        i_d       = (rover_q > last_q) ? '0 : POS_W'(rover_q);
        wrapped_d = 1'b0;
      end
      S_ITER: begin
        j_d   = i_q;
        end_d = i_q + POS_W'(s_q);
      end
      S_CHK: begin
        if (head_rd) begin
          if (fail) begin
            done_d              = 1'b1;
            rsp_d.status        = STAT_NO_SPACE;
            rsp_d.block_index   = '0;
            rsp_d.blocks_in_use = count_q;
          end else if (past_last) begin
            i_d       = '0;
            wrapped_d = 1'b1;
          end else begin
            i_d = i_new;
          end
        end else if (j_inc == end_q) begin
          head_we             = 1'b1;
          head_waddr          = AddrW'(i_q);
          head_wdata          = 1'b1;
          len_we              = 1'b1;
          rover_d             = CNT_W'(end_q);
          count_d             = (sum > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
          done_d              = 1'b1;
          rsp_d.status        = STAT_OK;
          rsp_d.block_index   = IDX_W'(i_q);
          rsp_d.blocks_in_use = count_d;
        end else begin
          j_d = j_inc;
        end
      end
      S_FREE: begin
        if (range_bad_q || !head_rd) begin
          done_d              = 1'b1;
          rsp_d.status        = STAT_BAD_FREE;
          rsp_d.block_index   = '0;
          rsp_d.blocks_in_use = count_q;
        end else begin
          head_we    = 1'b1;
          head_waddr = AddrW'(j_q);
          if (CNT_W'(j_q) < rover_q) begin
            rover_d = CNT_W'(j_q);
          end
          count_d             = (len_rd > count_q) ? '0 : count_q - len_rd;
          done_d              = 1'b1;
          rsp_d.status        = STAT_OK;
          rsp_d.block_index   = '0;
          rsp_d.blocks_in_use = count_d;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      rover_q   <= '0;
      count_q   <= '0;
      clr_q     <= '0;
      wrapped_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rover_q   <= rover_d;
      count_q   <= count_d;
      clr_q     <= clr_d;
      wrapped_q <= wrapped_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    last_q      <= last_d;
    i_q         <= i_d;
    j_q         <= j_d;
    end_q       <= end_d;
    range_bad_q <= range_bad_d;
    rsp_q       <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without preceding work");

  a_fail_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STAT_OK) |-> (rsp_o.block_index == '0))
    else $error("failed request reports a block index");

endmodule

/* dv/tb_next_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_block_allocator
// Self-checking bench for the next-fit block allocator. An in-bench pool
// predictor tracks head marks, run lengths, the roving pointer and the in-use
// count, and works out the reply to every request when it is taken. Replies
// are checked field by field in order. Directed size, free and register cases
// come first, then random allocate/free traffic over several pool settings.
// ----------------------------------------------------------------------------
module tb_next_fit_block_allocator;
  import nfba_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 16_000_000;
  localparam int COUNT_SAT   = 2047;
  localparam int BYTES_MAX   = 24'hFFFFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  req_t               req_i = '0;
  logic               done_o;
  rsp_t               rsp_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  next_fit_block_allocator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // pool predictor state
  bit               head_mark [NUM_BLOCKS];
  logic [LEN_W-1:0] run_blocks [NUM_BLOCKS];
  int               next_fit_ptr = 0;
  int               blocks_held = 0;
  int               cfg_unit = 64;
  int               cfg_pool = 1024;

  rsp_t pool_replies_due [$];
  rsp_t reply_want;
  int   mismatches = 0;
  int   cycles_run = 0;
  int   reply_tally [4] = '{0, 0, 0, 0};
  int   settings_used = 1;

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int pool_blocks();
    if (cfg_pool < 1) return 1;
    if (cfg_pool > NUM_BLOCKS) return NUM_BLOCKS;
    return cfg_pool;
  endfunction

  function automatic int unit_eff();
    return (cfg_unit == 0) ? 1 : cfg_unit;
  endfunction

  function automatic int hop_span(input int at);
    return (run_blocks[at] == 0) ? 1 : int'(run_blocks[at]);
  endfunction

  function automatic rsp_t predict_pool_reply(input req_t r);
    rsp_t o;
    int   unit, n, s, i, last, lim, it, j, hit, granted, bytes, len, idx;
    bit   wrapped;
    o = '0;
    o.status = STAT_OK;
    if (r.kind == KIND_ALLOC) begin
      unit = unit_eff();
      n = pool_blocks();
      bytes = int'(r.request_bytes);
      s = bytes / unit + ((bytes % unit) != 0 ? 1 : 0);
      granted = -1;
      wrapped = 1'b0;
      if (s == 0 || s > n) begin
        o.status = STAT_BAD_SIZE;
      end else begin
        last = n - s;
        i = next_fit_ptr;
        lim = 4 * n + 8;
        for (it = 0; it < lim; it++) begin
          if (i > last) i = 0;
          if (head_mark[i]) begin
            i += hop_span(i);
          end else begin
            hit = -1;
            for (j = i; j < i + s; j++) begin
              if (head_mark[j]) begin
                hit = j;
                break;
              end
            end
            if (hit < 0) begin
              granted = i;
              break;
            end
            i = hit + hop_span(hit);
          end
          if ((i >= next_fit_ptr || i > last) && wrapped) break;
          if (i > last) begin
            i = 0;
            wrapped = 1'b1;
          end
        end
        if (granted < 0) begin
          o.status = STAT_NO_SPACE;
        end else begin
          head_mark[granted] = 1'b1;
          run_blocks[granted] = s[LEN_W-1:0];
          next_fit_ptr = granted + s;
          blocks_held += s;
          if (blocks_held > COUNT_SAT) blocks_held = COUNT_SAT;
          o.block_index = granted[IDX_W-1:0];
        end
      end
    end else begin
      idx = int'(r.free_index);
      if (!head_mark[idx]) begin
        o.status = STAT_BAD_FREE;
      end else begin
        head_mark[idx] = 1'b0;
        if (idx < next_fit_ptr) next_fit_ptr = idx;
        len = int'(run_blocks[idx]);
        blocks_held = (len > blocks_held) ? 0 : blocks_held - len;
      end
    end
    o.blocks_in_use = blocks_held[CNT_W-1:0];
    return o;
  endfunction

  // reply checker: replies cannot be stalled, sample mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pool_replies_due.size() == 0) begin
        report_error($sformatf("reply with no request pending: st=%0d idx=%0d use=%0d",
                               rsp_o.status, rsp_o.block_index, rsp_o.blocks_in_use));
      end else begin
        reply_want = pool_replies_due.pop_front();
        if (rsp_o.status !== reply_want.status)
          report_error($sformatf("status exp %0d got %0d", reply_want.status, rsp_o.status));
        if (rsp_o.block_index !== reply_want.block_index)
          report_error($sformatf("block_index exp %0d got %0d",
                                 reply_want.block_index, rsp_o.block_index));
        if (rsp_o.blocks_in_use !== reply_want.blocks_in_use)
          report_error($sformatf("blocks_in_use exp %0d got %0d",
                                 reply_want.blocks_in_use, rsp_o.blocks_in_use));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding",
               cycles_run, pool_replies_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(input req_t r);
    rsp_t o;
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    o = predict_pool_reply(r);
    reply_tally[o.status]++;
    pool_replies_due.push_back(o);
  endtask

  task automatic alloc_bytes(input int bytes);
    req_t r;
    r = '0;
    r.kind = KIND_ALLOC;
    r.request_bytes = bytes[REQ_W-1:0];
    send_request(r);
  endtask

  task automatic free_block(input int idx);
    req_t r;
    r = '0;
    r.kind = KIND_FREE;
    r.free_index = idx[IDX_W-1:0];
    send_request(r);
  endtask

  task automatic sender_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pool_replies_due.size() != 0 || busy);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one APB transfer; entered and left at a rising edge with the bus idle
  task automatic apb_access(input bit wr, input reg_e r, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input reg_e r, input int want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, r, '0, rd);
    if (rd !== want[APB_DW-1:0])
      report_error($sformatf("register %0d read exp %0d got %0d", r, want, rd));
  endtask

  task automatic write_register(input reg_e r, input int value);
    logic [APB_DW-1:0] rd;
    wait_idle();
    apb_access(1'b1, r, value[APB_DW-1:0], rd);
    if (r == REG_UNIT_BYTES) cfg_unit = value & 16'hFFFF;
    else cfg_pool = value & 11'h7FF;
    check_register(r, (r == REG_UNIT_BYTES) ? cfg_unit : cfg_pool);
  endtask

  task automatic set_pool(input int unit, input int count);
    write_register(REG_UNIT_BYTES, unit);
    write_register(REG_BLOCK_COUNT, count);
    settings_used++;
  endtask

  function automatic req_t pick_request();
    req_t   r;
    int     n, unit, roll, k, kmax, b;
    longint bytes;
    int     heads [$];
    n = pool_blocks();
    unit = unit_eff();
    r.kind = KIND_ALLOC;
    r.request_bytes = REQ_W'($urandom);
    r.free_index = IDX_W'($urandom);
    roll = $urandom_range(0, 99);
    for (b = 0; b < NUM_BLOCKS; b++)
      if (head_mark[b]) heads.push_back(b);
    if (roll < 30 && heads.size() > 0) begin
      r.kind = KIND_FREE;
      r.free_index = IDX_W'(heads[$urandom_range(0, heads.size() - 1)]);
    end else if (roll < 36) begin
      r.kind = KIND_FREE;
    end else if (roll < 41) begin
      // wide random byte count, mostly oversize
    end else if (roll < 45) begin
      bytes = longint'(n) * unit + $urandom_range(1, unit);
      if (bytes > BYTES_MAX || $urandom_range(0, 1) == 0) bytes = 0;
      r.request_bytes = bytes[REQ_W-1:0];
    end else begin
      kmax = (roll < 52) ? n : ((n >= 4) ? n / 4 : 1);
      k = $urandom_range(1, kmax);
      bytes = longint'(k - 1) * unit + $urandom_range(1, unit);
      if (bytes > BYTES_MAX) bytes = BYTES_MAX;
      r.request_bytes = bytes[REQ_W-1:0];
    end
    return r;
  endfunction

  task automatic test_register_reset();
    wait_idle();
    check_register(REG_UNIT_BYTES, UNIT_RESET);
    check_register(REG_BLOCK_COUNT, COUNT_RESET);
  endtask

  task automatic test_size_limits();
    alloc_bytes(0);
    alloc_bytes(BYTES_MAX);
    alloc_bytes(1024 * 64 + 1);
    alloc_bytes(1);
    alloc_bytes(65);
    alloc_bytes(1021 * 64);
    alloc_bytes(64);
  endtask

  task automatic test_free_cases();
    free_block(2);
    free_block(1);
    free_block(1);
    free_block(1023);
    free_block(0);
    alloc_bytes(192);
    free_block(3);
    free_block(0);
  endtask

  task automatic test_register_extremes();
    set_pool(0, 0);
    alloc_bytes(1);
    alloc_bytes(1);
    alloc_bytes(2);
    free_block(0);
    set_pool(65535, 2047);
    alloc_bytes(BYTES_MAX);
    alloc_bytes(65535);
    free_block(0);
    free_block(257);
    set_pool(1, 2);
    alloc_bytes(2);
    alloc_bytes(1);
    free_block(0);
  endtask

  // runs stay live across settings, so shrinking and regrowing the pool
  // is exercised too
  task automatic test_random_traffic();
    int  units [6]  = '{64, 1, 4096, 65535, 0, 3};
    int  counts [6] = '{48, 16, 200, 8, 2, 1024};
    int  items [6]  = '{130, 120, 130, 110, 70, 120};
    int  p, k;
    bit  gaps_on;
    gaps_on = 1'b1;
    for (p = 0; p < 6; p++) begin
      set_pool(units[p], counts[p]);
      for (k = 0; k < items[p]; k++) begin
        if (k % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (p == 5 && k >= items[p] - 60) gaps_on = 1'b0;
        if (k == items[p] / 3) wait_idle();
        if (gaps_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
        send_request(pick_request());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_size_limits();
    test_free_cases();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("Covered %0d requests over %0d register settings, %0d mismatches",
             reply_tally[0] + reply_tally[1] + reply_tally[2] + reply_tally[3],
             settings_used, mismatches);
    $display("Replies: ok %0d, no space %0d, bad size %0d, bad free %0d",
             reply_tally[STAT_OK], reply_tally[STAT_NO_SPACE],
             reply_tally[STAT_BAD_SIZE], reply_tally[STAT_BAD_FREE]);
    if (mismatches == 0 && pool_replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
